// ===== hw/rtl/bsp_pkg.sv =====
// shared types, constants and fixed-point helpers of the slice polygon generator
package bsp_pkg;

    localparam int COORD_BITS  = 32;
    localparam int NUM_EDGES   = 12;
    localparam int MAX_VERTS   = 6;
    localparam int MIN_VERTS   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_BITS = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_Z = 3'd5;

    typedef logic signed [63:0] t_w;

    localparam t_w CHI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam t_w CLO = -CHI - 64'sd1;

    // box edges: start corner (bit 2 = x max, bit 1 = y max, bit 0 = z max) and axis
    localparam logic [2:0] EDGE_START [NUM_EDGES] = '{0, 2, 4, 0, 1, 3, 5, 1, 0, 2, 6, 4};
    localparam logic [1:0] EDGE_AXIS  [NUM_EDGES] = '{1, 0, 1, 0, 1, 0, 1, 0, 2, 2, 2, 2};

    typedef struct packed {
        logic [2:0][63:0] geo;
        logic [2:0][63:0] tex;
    } t_boxes;

    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][31:0] dir;
        logic [31:0]      t;
    } t_slice;

    typedef struct packed {
        logic [2:0]                     count;
        logic [2:0][31:0]               dir;
        logic [MAX_VERTS-1:0][2:0][31:0] pos;
        logic [MAX_VERTS-1:0][2:0][31:0] tex;
    } t_poly;

    function automatic t_w sx(input logic [31:0] v);
        return t_w'(signed'(v));
    endfunction

    function automatic logic [31:0] sat32(input t_w x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [31:0] satc(input t_w x);
        if (x > CHI) return CHI[31:0];
        if (x < CLO) return CLO[31:0];
        return x[31:0];
    endfunction

    // q16.16 product, rounded half up, saturated
    function automatic logic [31:0] mulq(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        t_w pr;
        pr = a * b;
        pr = pr + 64'sd32768;
        return sat32(pr >>> 16);
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/bsp_in_if.sv =====
// slice item channel
interface bsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] slice_t;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, slice_t,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, slice_t,
                  output ready);
endinterface

// ===== hw/rtl/bsp_out_if.sv =====
// polygon vertex channel
interface bsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tcoord_x;
    logic signed [31:0] tcoord_y;
    logic signed [31:0] tcoord_z;
    logic [2:0]         vertex_slot;
    logic [2:0]         vertex_count;
    logic               last;

    modport source (output valid, pos_x, pos_y, pos_z, tcoord_x, tcoord_y, tcoord_z,
                    vertex_slot, vertex_count, last, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tcoord_x, tcoord_y, tcoord_z,
                  vertex_slot, vertex_count, last, output ready);
endinterface

// ===== hw/rtl/bsp_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module bsp_div #(
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_rem0,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [DW:0]   trial;
    logic          take;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_q[QW-1]};
    assign take  = trial >= {1'b0, r_den};

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_den <= i_den;
            r_q   <= i_lo;
        end else if (r_busy) begin
            r_rem <= take ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hw/rtl/bsp_front.sv =====
// front end: takes slice items and finds the box edge crossings
module bsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsp_pkg::t_boxes i_box,
    bsp_in_if.sink          i_slice,
    output bsp_pkg::t_poly  o_poly,
    output logic            o_push,
    input  logic            i_room
);
    import bsp_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PNT  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_DEN  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_UPK  = 4'd6;
    localparam logic [3:0] S_UPT  = 4'd7;
    localparam logic [3:0] S_NEXT = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam logic [3:0] LAST_EDGE = 4'(NUM_EDGES - 1);

    logic [3:0]   r_state;
    logic         r_buf_v;
    t_slice       r_buf;
    logic [1:0]   r_i;
    logic [3:0]   r_edge;
    logic [3:0]   r_n;
    logic [2:0][31:0] r_o;
    logic [2:0][31:0] r_d;
    logic [31:0]  r_t;
    logic [2:0][31:0] r_p;
    logic signed [34:0] r_acc;
    logic signed [31:0] r_s;
    logic signed [31:0] r_den;
    logic [16:0]  r_u;
    logic [MAX_VERTS-1:0][2:0][31:0] r_pos;
    logic [MAX_VERTS-1:0][2:0][31:0] r_tex;

    logic [2:0]   corner;
    logic [1:0]   axis;
    t_w           a_g [3];
    t_w           a_t [3];
    logic [31:0]  len_g;
    logic [31:0]  len_t;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [31:0]  mul_r;
    logic         hit;
    logic         keep;
    logic [31:0]  abs_s;
    logic [31:0]  abs_den;
    logic [47:0]  num;
    logic         div_done;
    logic [16:0]  div_quo;

    // input beat buffer, so a new item waits while the current one is worked
    assign i_slice.ready = !r_buf_v;

    // start corner and length of the current edge in both boxes
    assign corner = EDGE_START[r_edge];
    assign axis   = EDGE_AXIS[r_edge];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_g[i] = corner[2-i] ? sx(i_box.geo[i][63:32]) : sx(i_box.geo[i][31:0]);
            a_t[i] = corner[2-i] ? sx(i_box.tex[i][63:32]) : sx(i_box.tex[i][31:0]);
        end
        len_g = sat32(sx(i_box.geo[axis][63:32]) - sx(i_box.geo[axis][31:0]));
        len_t = sat32(sx(i_box.tex[axis][63:32]) - sx(i_box.tex[axis][31:0]));
    end

    // one shared multiplier
    always_comb begin
        mul_a = r_t;
        mul_b = r_d[r_i];
        case (r_state)
            S_SUM: begin
                mul_a = sat32(sx(r_p[r_i]) - a_g[r_i]);
                mul_b = r_d[r_i];
            end
            S_DEN: begin
                mul_a = len_g;
                mul_b = r_d[axis];
            end
            S_UPK: begin
                mul_a = {15'd0, r_u};
                mul_b = len_g;
            end
            S_UPT: begin
                mul_a = {15'd0, r_u};
                mul_b = len_t;
            end
            default: ;
        endcase
    end
    assign mul_r = mulq(mul_a, mul_b);

    // crossing test and edge fraction
    assign hit = (r_den != 32'sd0) &&
                 ((r_den > 32'sd0) ? !(r_s < 32'sd0 || r_s > r_den)
                                   : !(r_s > 32'sd0 || r_s < r_den));
    assign abs_s   = abs32(r_s);
    assign abs_den = abs32(r_den);
    assign num     = {abs_s, 16'd0} + 48'(abs_den >> 1);

    bsp_div #(.DW(32), .QW(17)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CHK && hit),
        .i_rem0  (32'(num[47:17])),
        .i_lo    (num[16:0]),
        .i_den   (abs_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign keep   = (r_n >= 4'(MIN_VERTS)) && (r_n <= 4'(MAX_VERTS));
    assign o_push = (r_state == S_FIN) && keep && i_room;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_buf_v <= 1'b0;
            r_i     <= '0;
            r_edge  <= '0;
            r_n     <= '0;
        end else begin
            if (i_slice.valid && i_slice.ready) r_buf_v <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (r_buf_v) begin
                        r_buf_v <= 1'b0;
                        r_i     <= '0;
                        r_edge  <= '0;
                        r_n     <= '0;
                        r_state <= S_PNT;
                    end
                end
                S_PNT, S_SUM: begin
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= (r_state == S_PNT) ? S_SUM : S_DEN;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_DEN: r_state <= S_CHK;
                S_CHK: r_state <= hit ? S_DIV : S_NEXT;
                S_DIV: begin
                    if (div_done) r_state <= S_UPK;
                end
                S_UPK: r_state <= S_UPT;
                S_UPT: begin
                    r_n     <= r_n + 4'd1;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_edge == LAST_EDGE) begin
                        r_state <= S_FIN;
                    end else begin
                        r_edge  <= r_edge + 4'd1;
                        r_state <= S_SUM;
                    end
                end
                S_FIN: begin
                    if (!keep || i_room) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_slice.valid && i_slice.ready) begin
            r_buf.origin <= {i_slice.origin_z, i_slice.origin_y, i_slice.origin_x};
            r_buf.dir    <= {i_slice.dir_z, i_slice.dir_y, i_slice.dir_x};
            r_buf.t      <= i_slice.slice_t;
        end
        case (r_state)
            S_IDLE: begin
                r_o <= r_buf.origin;
                r_d <= r_buf.dir;
                r_t <= r_buf.t;
            end
            S_PNT: r_p[r_i] <= satc(sx(r_o[r_i]) + sx(mul_r));
            S_SUM: r_acc <= ((r_i == 2'd0) ? 35'sd0 : r_acc) + 35'(sx(mul_r));
            S_DEN: begin
                r_den <= signed'(mul_r);
                r_s   <= signed'(sat32(t_w'(r_acc)));
            end
            S_DIV: begin
                if (div_done) r_u <= div_quo;
            end
            S_UPK: begin
                if (r_n < 4'(MAX_VERTS)) begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[r_n[2:0]][i] <= (2'(i) == axis) ? satc(a_g[i] + sx(mul_r))
                                                              : satc(a_g[i]);
                        r_tex[r_n[2:0]][i] <= satc(a_t[i]);
                    end
                end
            end
            S_UPT: begin
                if (r_n < 4'(MAX_VERTS)) r_tex[r_n[2:0]][axis] <= satc(a_t[axis] + sx(mul_r));
            end
            default: ;
        endcase
    end

    assign o_poly.count = r_n[2:0];
    assign o_poly.dir   = r_d;
    assign o_poly.pos   = r_pos;
    assign o_poly.tex   = r_tex;

endmodule

// ===== hw/rtl/bsp_back.sv =====
// back end: orders non-triangles by pseudo-angle and sends the vertices
module bsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsp_pkg::t_poly i_poly,
    input  logic           i_valid,
    output logic           o_pop,
    bsp_out_if.source      o_vertex
);
    import bsp_pkg::*;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RT   = 4'd1;
    localparam logic [3:0] B_CEN  = 4'd2;
    localparam logic [3:0] B_CENW = 4'd3;
    localparam logic [3:0] B_VEC  = 4'd4;
    localparam logic [3:0] B_PAD  = 4'd5;
    localparam logic [3:0] B_PAW  = 4'd6;
    localparam logic [3:0] B_SORT = 4'd7;
    localparam logic [3:0] B_EMIT = 4'd8;

    localparam logic [18:0] PAD_KEY = '1;
    localparam logic [18:0] PA_TWO  = 19'd131072;
    localparam logic [18:0] PA_FOUR = 19'd262144;
    localparam logic [2:0]  LAST_STEP = 3'd5;

    logic [3:0]   r_state;
    logic [2:0]   r_i;
    logic [2:0]   r_j;
    t_poly        r_rec;
    logic [31:0]  r_m;
    logic [2:0][31:0] r_rt;
    logic [2:0][32:0] r_vc;
    logic signed [34:0] r_ax;
    logic signed [34:0] r_ay;
    logic [31:0]  r_vx;
    logic [31:0]  r_vy;
    logic [18:0]  r_pa  [MAX_VERTS];
    logic [2:0]   r_idx [MAX_VERTS];
    logic         r_ov;
    logic [2:0][31:0] r_opos;
    logic [2:0][31:0] r_otex;
    logic [2:0]   r_oslot;
    logic [2:0]   r_ocnt;
    logic         r_olast;

    logic [31:0]  ad [3];
    logic [1:0]   sel;
    logic [31:0]  up [3];
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [31:0]  mul_r;
    logic [1:0]   ii;
    logic signed [34:0] csum;
    logic [34:0]  clo;
    logic         cdiv_done;
    logic [34:0]  cdiv_quo;
    logic [31:0]  vx_c;
    logic [31:0]  vy_c;
    logic [32:0]  pden;
    logic [47:0]  pnum;
    logic         pdiv_done;
    logic [16:0]  pdiv_quo;
    logic [18:0]  pa_new;
    logic [18:0]  n_pa  [MAX_VERTS];
    logic [2:0]   n_idx [MAX_VERTS];
    logic         last_v;
    logic         out_load;

    assign last_v   = (r_j == r_rec.count - 3'd1);
    assign out_load = (r_state == B_EMIT) && (!r_ov || o_vertex.ready);
    assign o_pop    = (r_state == B_IDLE) && i_valid;

    // up vector from the smallest direction component
    always_comb begin
        for (int i = 0; i < 3; i++) ad[i] = abs32(r_rec.dir[i]);
        if (ad[0] < ad[1]) sel = (ad[0] < ad[2]) ? 2'd0 : 2'd2;
        else sel = (ad[1] < ad[2]) ? 2'd1 : 2'd2;
        case (sel)
            2'd0: begin
                up[0] = '0;
                up[1] = sat32(-sx(r_rec.dir[2]));
                up[2] = r_rec.dir[1];
            end
            2'd1: begin
                up[0] = sat32(-sx(r_rec.dir[2]));
                up[1] = '0;
                up[2] = r_rec.dir[0];
            end
            default: begin
                up[0] = sat32(-sx(r_rec.dir[1]));
                up[1] = r_rec.dir[0];
                up[2] = '0;
            end
        endcase
    end

    // one shared multiplier: right vector, then projections
    assign ii = (r_i < 3'd3) ? r_i[1:0] : 2'(r_i - 3'd3);
    always_comb begin
        mul_a = sat32(sx(r_rec.pos[r_j][ii]) - t_w'(signed'(r_vc[ii])));
        mul_b = (r_i < 3'd3) ? r_rt[ii] : up[ii];
        if (r_state == B_RT) begin
            case (r_i)
                3'd0: begin mul_a = r_rec.dir[1]; mul_b = up[2]; end
                3'd1: begin mul_a = r_rec.dir[2]; mul_b = up[1]; end
                3'd2: begin mul_a = r_rec.dir[2]; mul_b = up[0]; end
                3'd3: begin mul_a = r_rec.dir[0]; mul_b = up[2]; end
                3'd4: begin mul_a = r_rec.dir[0]; mul_b = up[1]; end
                default: begin mul_a = r_rec.dir[1]; mul_b = up[0]; end
            endcase
        end
    end
    assign mul_r = mulq(mul_a, mul_b);

    // centroid sum of one axis
    always_comb begin
        csum = '0;
        for (int j = 0; j < MAX_VERTS; j++) begin
            if (3'(j) < r_rec.count) csum = csum + 35'(sx(r_rec.pos[j][r_i[1:0]]));
        end
        clo = (csum[34] ? 35'(-csum) : 35'(csum)) + 35'(r_rec.count >> 1);
    end

    bsp_div #(.DW(3), .QW(35)) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_CEN),
        .i_rem0  (3'd0),
        .i_lo    (clo),
        .i_den   (r_rec.count),
        .o_done  (cdiv_done),
        .o_quo   (cdiv_quo)
    );

    // pseudo-angle division
    assign vx_c = sat32(t_w'(r_ax));
    assign vy_c = sat32(t_w'(r_ay));
    assign pden = {1'b0, abs32(vx_c)} + {1'b0, abs32(vy_c)};
    assign pnum = {abs32(vy_c), 16'd0} + 48'(pden >> 1);

    bsp_div #(.DW(33), .QW(17)) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_PAD && pden != '0),
        .i_rem0  (33'(pnum[47:17])),
        .i_lo    (pnum[16:0]),
        .i_den   (pden),
        .o_done  (pdiv_done),
        .o_quo   (pdiv_quo)
    );

    // quadrant fold of the pseudo-angle
    always_comb begin
        if (r_vx[31]) pa_new = r_vy[31] ? PA_TWO + 19'(pdiv_quo) : PA_TWO - 19'(pdiv_quo);
        else if (r_vy[31]) pa_new = PA_FOUR - 19'(pdiv_quo);
        else pa_new = 19'(pdiv_quo);
    end

    // one odd-even transposition pass, swapping only on strictly greater
    always_comb begin
        for (int k = 0; k < MAX_VERTS; k++) begin
            n_pa[k]  = r_pa[k];
            n_idx[k] = r_idx[k];
        end
        for (int k = 0; k + 1 < MAX_VERTS; k++) begin
            if ((k % 2) == (r_i[0] ? 1 : 0) && r_pa[k] > r_pa[k+1]) begin
                n_pa[k]    = r_pa[k+1];
                n_pa[k+1]  = r_pa[k];
                n_idx[k]   = r_idx[k+1];
                n_idx[k+1] = r_idx[k];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (o_vertex.ready) r_ov <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= (i_poly.count == 3'(MIN_VERTS)) ? B_EMIT : B_RT;
                    end
                end
                B_RT: begin
                    if (r_i == LAST_STEP) begin
                        r_i     <= '0;
                        r_state <= B_CEN;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                B_CEN: r_state <= B_CENW;
                B_CENW: begin
                    if (cdiv_done) begin
                        if (r_i == 3'd2) begin
                            r_i     <= '0;
                            r_state <= B_VEC;
                        end else begin
                            r_i     <= r_i + 3'd1;
                            r_state <= B_CEN;
                        end
                    end
                end
                B_VEC: begin
                    if (r_i == LAST_STEP) begin
                        r_i     <= '0;
                        r_state <= B_PAD;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                B_PAD, B_PAW: begin
                    if ((r_state == B_PAD && pden == '0) || (r_state == B_PAW && pdiv_done)) begin
                        if (last_v) begin
                            r_state <= B_SORT;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= B_VEC;
                        end
                    end else if (r_state == B_PAD) begin
                        r_state <= B_PAW;
                    end
                end
                B_SORT: begin
                    if (r_i == LAST_STEP) begin
                        r_j     <= '0;
                        r_state <= B_EMIT;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                B_EMIT: begin
                    if (out_load) begin
                        if (last_v) r_state <= B_IDLE;
                        else r_j <= r_j + 3'd1;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    r_rec <= i_poly;
                    for (int k = 0; k < MAX_VERTS; k++) begin
                        r_idx[k] <= 3'(k);
                        r_pa[k]  <= PAD_KEY;
                    end
                end
            end
            B_RT: begin
                if (r_i[0]) r_rt[r_i[2:1]] <= sat32(sx(r_m) - sx(mul_r));
                else r_m <= mul_r;
            end
            B_CENW: begin
                if (cdiv_done) r_vc[r_i[1:0]] <= csum[34] ? 33'(-cdiv_quo) : cdiv_quo[32:0];
            end
            B_VEC: begin
                if (r_i < 3'd3) r_ax <= ((r_i == 3'd0) ? 35'sd0 : r_ax) + 35'(sx(mul_r));
                else r_ay <= ((r_i == 3'd3) ? 35'sd0 : r_ay) + 35'(sx(mul_r));
            end
            B_PAD: begin
                r_vx <= vx_c;
                r_vy <= vy_c;
                if (pden == '0) r_pa[r_j] <= '0;
            end
            B_PAW: begin
                if (pdiv_done) r_pa[r_j] <= pa_new;
            end
            B_SORT: begin
                for (int k = 0; k < MAX_VERTS; k++) begin
                    r_pa[k]  <= n_pa[k];
                    r_idx[k] <= n_idx[k];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_opos  <= r_rec.pos[r_idx[r_j]];
            r_otex  <= r_rec.tex[r_idx[r_j]];
            r_oslot <= r_j;
            r_ocnt  <= r_rec.count;
            r_olast <= last_v;
        end
    end

    // output register
    assign o_vertex.valid        = r_ov;
    assign o_vertex.pos_x        = r_opos[0];
    assign o_vertex.pos_y        = r_opos[1];
    assign o_vertex.pos_z        = r_opos[2];
    assign o_vertex.tcoord_x     = r_otex[0];
    assign o_vertex.tcoord_y     = r_otex[1];
    assign o_vertex.tcoord_z     = r_otex[2];
    assign o_vertex.vertex_slot  = r_oslot;
    assign o_vertex.vertex_count = r_ocnt;
    assign o_vertex.last         = r_olast;

endmodule

// ===== hw/rtl/box_slice_polygon_generator.sv =====
// top level of the slice polygon generator: registers, polygon queue, front and back
//
// Each slice beat is cut against the configured box and turned into 3 to 6 ordered
// vertex beats, the last one marked; slices with fewer than 3 or more than 6 crossings
// give no beats. The front end's pace is set by its single shared multiplier and its
// 17-step divider; the back end, on a polygon of 4 to 6 vertices, runs three 35-step
// centroid divisions and up to one 17-step pseudo-angle division per vertex, while a
// triangle skips the ordering and is sent straight out. A two-entry polygon queue lets
// the two ends run apart, and an input buffer takes the next slice while the current
// one is worked, so the sustained rate is set by the slower of the two ends.
// Configuration is to be written only while the block is idle; the user is bound to
// this, and the block itself does not enforce it.
module box_slice_polygon_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bsp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [63:0]                        i_cfg_data,
    bsp_in_if.sink                             i_slice,
    bsp_out_if.source                          o_vertex
);
    import bsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [2:0][63:0] r_geo;
    logic [2:0][63:0] r_tex;
    t_boxes           boxes;
    t_poly            r_q [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [NW-1:0]    r_cnt;
    t_poly            f_poly;
    logic             push;
    logic             pop;
    logic             room;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo <= '0;
            r_tex <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BOX_X: r_geo[0] <= i_cfg_data;
                REG_BOX_Y: r_geo[1] <= i_cfg_data;
                REG_BOX_Z: r_geo[2] <= i_cfg_data;
                REG_TEX_X: r_tex[0] <= i_cfg_data;
                REG_TEX_Y: r_tex[1] <= i_cfg_data;
                REG_TEX_Z: r_tex[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign boxes.geo = r_geo;
    assign boxes.tex = r_tex;

    bsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (boxes),
        .i_slice (i_slice),
        .o_poly  (f_poly),
        .o_push  (push),
        .i_room  (room)
    );

    // polygon queue between the two ends
    assign room = (r_cnt != NW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (pop) r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (push && !pop) r_cnt <= r_cnt + NW'(1);
            else if (pop && !push) r_cnt <= r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= f_poly;
    end

    bsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poly   (r_q[r_rd]),
        .i_valid  (r_cnt != '0),
        .o_pop    (pop),
        .o_vertex (o_vertex)
    );

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex.valid |-> (o_vertex.vertex_count >= 3'(MIN_VERTS) &&
                            o_vertex.vertex_count <= 3'(MAX_VERTS) &&
                            o_vertex.vertex_slot < o_vertex.vertex_count))
        else $error("vertex beat with bad count or slot");

    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vertex.valid && o_vertex.last) |->
            (o_vertex.vertex_slot == o_vertex.vertex_count - 3'd1))
        else $error("last flag not on the final slot");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= NW'(QUEUE_DEPTH)) && !(push && !room) && !(pop && r_cnt == '0))
        else $error("polygon queue overrun or underrun");

    a_next_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vertex.valid && o_vertex.ready && !o_vertex.last) |=>
            (!o_vertex.valid || o_vertex.vertex_slot == $past(o_vertex.vertex_slot) + 3'd1))
        else $error("vertex slots out of sequence");

endmodule
